[hw/rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

    // Field widths of the transaction ports
    localparam int DATA_W        = 32;
    localparam int PRIO_PORT_W   = 8;
    localparam int STATUS_W      = 2;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the new pair, queue not full
        logic rem;   // remove the front entry, queue not empty
    } cell_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
`default_nettype none

module spq_cell #(
    parameter int SW = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire spq_pkg::cell_cmd_t          cmd,
    input  wire signed [spq_pkg::DATA_W-1:0] new_data,
    input  wire        [SW-1:0]              new_prio,
    input  wire                              left_valid,
    input  wire signed [spq_pkg::DATA_W-1:0] left_data,
    input  wire        [SW-1:0]              left_prio,
    input  wire                              right_valid,
    input  wire signed [spq_pkg::DATA_W-1:0] right_data,
    input  wire        [SW-1:0]              right_prio,
    output logic                             valid,
    output logic signed [spq_pkg::DATA_W-1:0] data,
    output logic       [SW-1:0]              prio
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [spq_pkg::DATA_W-1:0] data_reg;
    logic signed [spq_pkg::DATA_W-1:0] data_next;
    logic        [SW-1:0]              prio_reg;
    logic        [SW-1:0]              prio_next;
    logic                              keep_self;
    logic                              left_keeps;

    // An entry of equal or higher priority stays ahead of the new pair
    assign keep_self  = valid_reg && (prio_reg >= new_prio);
    assign left_keeps = left_valid && (left_prio >= new_prio);

    // Hold, take the new pair, shift back from the left, or advance from the right
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (cmd.ins)
        begin
            if (!keep_self)
            begin
                if (left_keeps)
                begin
                    valid_next = 1'b1;
                    data_next  = new_data;
                    prio_next  = new_prio;
                end
                else
                begin
                    valid_next = left_valid;
                    data_next  = left_data;
                    prio_next  = left_prio;
                end
            end
        end
        else if (cmd.rem)
        begin
            valid_next = right_valid;
            data_next  = right_data;
            prio_next  = right_prio;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Bounded priority queue of DEPTH data/priority pairs, held sorted in a chain of
// cells with the highest priority at the front. An insert lands behind every
// entry of equal or higher priority, so equal priorities leave in arrival order;
// an insert into a full queue is dropped with status full, a remove from an
// empty queue returns status empty. Every cell compares against the broadcast
// request and shifts with its neighbour in the same cycle, so a new transaction
// is accepted every cycle; the result sits in an output register from the cycle
// after acceptance, and the input stalls only while that register holds a
// result the output side has not taken. Only the low PRIO_BITS bits of
// priority_in are used (at most the 8-bit port width).
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    req_type,
    input  wire signed [spq_pkg::DATA_W-1:0]       data_in,
    input  wire        [spq_pkg::PRIO_PORT_W-1:0]  priority_in,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]      data_out,
    output logic       [spq_pkg::PRIO_PORT_W-1:0]  priority_out,
    output logic       [spq_pkg::STATUS_W-1:0]     status,
    output logic       [CW-1:0]                    entry_count
);

    localparam int SW = (PRIO_BITS < spq_pkg::PRIO_PORT_W) ? PRIO_BITS
                                                           : spq_pkg::PRIO_PORT_W;

    logic [DEPTH-1:0]                                valid_vec;
    logic [DEPTH-1:0][spq_pkg::DATA_W-1:0]           data_arr;
    logic [DEPTH-1:0][SW-1:0]                        prio_arr;

    logic [CW-1:0]                                   count_reg;
    logic [CW-1:0]                                   count_next;
    logic                                            out_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0]               data_out_reg;
    logic signed [spq_pkg::DATA_W-1:0]               data_out_next;
    logic [spq_pkg::PRIO_PORT_W-1:0]                 priority_out_reg;
    logic [spq_pkg::PRIO_PORT_W-1:0]                 priority_out_next;
    logic [spq_pkg::STATUS_W-1:0]                    status_reg;
    logic [spq_pkg::STATUS_W-1:0]                    status_next;

    logic                                            accept;
    logic                                            full;
    logic                                            empty;
    logic [SW-1:0]                                   new_prio;
    spq_pkg::cell_cmd_t                              cmd;

    // Accept whenever the output register is free or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full     = valid_vec[DEPTH-1];
    assign empty    = !valid_vec[0];
    assign new_prio = priority_in[SW-1:0];

    assign cmd = '{
        ins: accept && (req_type == spq_pkg::REQ_INSERT) && !full,
        rem: accept && (req_type == spq_pkg::REQ_REMOVE) && !empty
    };

    // Chain of cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                              lv;
        logic signed [spq_pkg::DATA_W-1:0] ld;
        logic        [SW-1:0]              lp;
        logic                              rv;
        logic signed [spq_pkg::DATA_W-1:0] rd;
        logic        [SW-1:0]              rp;

        // The front sees a left neighbour that always ranks equal to or above the new pair
        if (i == 0)
        begin : g_front
            assign lv = 1'b1;
            assign ld = '0;
            assign lp = '1;
        end
        else
        begin : g_left
            assign lv = valid_vec[i-1];
            assign ld = data_arr[i-1];
            assign lp = prio_arr[i-1];
        end

        // The tail takes an empty slot on a remove
        if (i == DEPTH - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rd = '0;
            assign rp = '0;
        end
        else
        begin : g_right
            assign rv = valid_vec[i+1];
            assign rd = data_arr[i+1];
            assign rp = prio_arr[i+1];
        end

        spq_cell #(
            .SW (SW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_data    (data_in),
            .new_prio    (new_prio),
            .left_valid  (lv),
            .left_data   (ld),
            .left_prio   (lp),
            .right_valid (rv),
            .right_data  (rd),
            .right_prio  (rp),
            .valid       (valid_vec[i]),
            .data        (data_arr[i]),
            .prio        (prio_arr[i])
        );
    end

    // Form the result of the accepted transaction
    always_comb
    begin
        count_next        = count_reg;
        data_out_next     = '0;
        priority_out_next = '0;
        if (req_type == spq_pkg::REQ_INSERT)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                status_next = spq_pkg::ST_INSERTED;
                count_next  = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next       = spq_pkg::ST_REMOVED;
                count_next        = count_reg - CW'(1);
                data_out_next     = data_arr[0];
                priority_out_next = spq_pkg::PRIO_PORT_W'(prio_arr[0]);
            end
        end
    end

    // Control: entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg     <= data_out_next;
            priority_out_reg <= priority_out_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_out     = data_out_reg;
    assign priority_out = priority_out_reg;
    assign status       = status_reg;
    assign entry_count  = count_reg;

    // Occupied cells always form a prefix whose length is the entry count
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_vec) == int'(count_reg)) &&
        ((valid_vec & (valid_vec + DEPTH'(1))) == '0))
        else $error("cell occupancy disagrees with entry count");

    // An insert into a full queue reports full and leaves the count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == spq_pkg::REQ_INSERT) && full) |=>
        (status_reg == spq_pkg::ST_FULL) && (count_reg == CW'(DEPTH)))
        else $error("insert into full queue not dropped");

    // A remove hands out the entry that stood at the front
    a_remove_front: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == spq_pkg::REQ_REMOVE) && !empty) |=>
        (status_reg == spq_pkg::ST_REMOVED) &&
        (data_out_reg == $past(data_arr[0])))
        else $error("removed entry is not the former front");

    // While the queue is not full, the front never ranks below its follower
    a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[DEPTH-1:DEPTH-1] != 1'b0 || DEPTH < 2 || !valid_vec[1] ||
        (prio_arr[0] >= prio_arr[1]))
        else $error("front entry outranked by its follower");

endmodule

`default_nettype wire

[dv/sorted_priority_queue_tb.sv]
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int DATA_W      = spq_pkg::DATA_W;
    localparam int PRIO_PORT_W = spq_pkg::PRIO_PORT_W;
    localparam int STATUS_W    = spq_pkg::STATUS_W;
    localparam int DEPTH       = spq_pkg::DEPTH_DEF;
    localparam int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [PRIO_PORT_W-1:0] PRIO_MASK =
        PRIO_PORT_W'((64'd1 << PRIO_BITS) - 64'd1);

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_PORT_W-1:0]   prio;
        logic [STATUS_W-1:0]      st;
        logic [CNT_W-1:0]         cnt;
    } queue_result_t;

    typedef struct {
        logic                     req;
        logic signed [DATA_W-1:0] data;
        logic [PRIO_PORT_W-1:0]   prio;
        int                       reps;
        bit                       typed;
        queue_result_t            want;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           req_type = spq_pkg::REQ_INSERT;
    logic signed [DATA_W-1:0]       data_in = '0;
    logic [PRIO_PORT_W-1:0]         priority_in = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [DATA_W-1:0]       data_out;
    logic [PRIO_PORT_W-1:0]         priority_out;
    logic [STATUS_W-1:0]            status;
    logic [CNT_W-1:0]               entry_count;

    // Mirror of the queue contents, front at index 0
    logic signed [DATA_W-1:0]       held_data [DEPTH];
    logic [PRIO_PORT_W-1:0]         held_prio [DEPTH];
    int                             held_n = 0;

    queue_result_t                  pending_results [$];
    stim_row_t                      directed_rows [$];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  items_sent    = 0;
    int  inserted_n    = 0;
    int  removed_n     = 0;
    int  full_n        = 0;
    int  empty_n       = 0;
    int  peak_count    = 0;
    int  idle_cycles   = 0;
    bit  hold_off_req  = 1'b0;
    bit  send_quiet    = 1'b0;
    bit  take_quiet    = 1'b0;

    sorted_priority_queue #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .data_in      (data_in),
        .priority_in  (priority_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_out     (data_out),
        .priority_out (priority_out),
        .status       (status),
        .entry_count  (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic queue_result_t mk_result(input logic signed [DATA_W-1:0] d,
                                                input logic [PRIO_PORT_W-1:0] p,
                                                input logic [STATUS_W-1:0] st,
                                                input int cnt);
        queue_result_t r;
        r.data = d;
        r.prio = p;
        r.st   = st;
        r.cnt  = CNT_W'(cnt);
        return r;
    endfunction

    // Apply one request to the mirror and return the result it should produce
    function automatic queue_result_t serve_request(input logic req,
                                                    input logic signed [DATA_W-1:0] d,
                                                    input logic [PRIO_PORT_W-1:0] p_raw);
        queue_result_t r;
        logic [PRIO_PORT_W-1:0] p;
        int pos;
        int k;
        p = p_raw & PRIO_MASK;
        r = '0;
        if (req == spq_pkg::REQ_INSERT)
        begin
            if (held_n >= DEPTH)
            begin
                r.st = spq_pkg::ST_FULL;
            end
            else
            begin
                // land behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_n && held_prio[pos] >= p)
                    pos++;
                for (k = held_n; k > pos; k--)
                begin
                    held_data[k] = held_data[k-1];
                    held_prio[k] = held_prio[k-1];
                end
                held_data[pos] = d;
                held_prio[pos] = p;
                held_n++;
                r.st = spq_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (held_n == 0)
            begin
                r.st = spq_pkg::ST_EMPTY;
            end
            else
            begin
                // take the front and close the gap
                r.data = held_data[0];
                r.prio = held_prio[0];
                for (k = 1; k < held_n; k++)
                begin
                    held_data[k-1] = held_data[k];
                    held_prio[k-1] = held_prio[k];
                end
                held_n--;
                r.st = spq_pkg::ST_REMOVED;
            end
        end
        r.cnt = CNT_W'(held_n);
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h",
                 results_seen, what, got, want);
    endtask

    task automatic add_row(input logic req, input logic signed [DATA_W-1:0] d,
                           input logic [PRIO_PORT_W-1:0] p, input int reps,
                           input bit typed, input queue_result_t want);
        stim_row_t row;
        row.req   = req;
        row.data  = d;
        row.prio  = p;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Offer one transaction, hold it until accepted, then record its expectation
    task automatic send_item(input logic req, input logic signed [DATA_W-1:0] d,
                             input logic [PRIO_PORT_W-1:0] p, input int gap,
                             input bit typed, input queue_result_t want);
        queue_result_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        data_in     <= d;
        priority_in <= p;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = serve_request(req, d, p);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Result side: stall at random, take a transaction, compare with the oldest expectation
    initial
    begin
        queue_result_t want;
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                take_quiet = !take_quiet;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = pick_gap(take_quiet);
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            results_seen++;
            case (status)
                spq_pkg::ST_INSERTED: inserted_n++;
                spq_pkg::ST_REMOVED:  removed_n++;
                spq_pkg::ST_FULL:     full_n++;
                default:              empty_n++;
            endcase
            if (int'(entry_count) > peak_count)
                peak_count = int'(entry_count);
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, nothing pending", status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (data_out !== want.data)
                    report_mismatch("data_out", data_out, want.data);
                if (priority_out !== want.prio)
                    report_mismatch("priority_out", priority_out, want.prio);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (entry_count !== want.cnt)
                    report_mismatch("entry_count", entry_count, want.cnt);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then biased random traffic
    initial
    begin
        stim_row_t row;
        logic req;
        logic signed [DATA_W-1:0] d;
        logic [PRIO_PORT_W-1:0] p;
        int ins_pct;
        int burst_left;
        int gap;
        int sel;

        // Empty remove, the maximum data at top priority and the minimum data at the lowest,
        // ties leaving in arrival order, fill to the limit and a dropped insert
        add_row(spq_pkg::REQ_REMOVE, 32'sh1234_5678, 8'h77, 1, 1'b1,
                mk_result(0, 0, spq_pkg::ST_EMPTY, 0));
        add_row(spq_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 8'hFF, 1, 1'b1,
                mk_result(0, 0, spq_pkg::ST_INSERTED, 1));
        add_row(spq_pkg::REQ_REMOVE, 32'sh0, 8'h0, 1, 1'b1,
                mk_result(32'sh7FFF_FFFF, 8'hFF, spq_pkg::ST_REMOVED, 0));
        add_row(spq_pkg::REQ_INSERT, 32'sh8000_0000, 8'h00, 1, 1'b1,
                mk_result(0, 0, spq_pkg::ST_INSERTED, 1));
        add_row(spq_pkg::REQ_INSERT, 32'sh1, 8'h05, 1, 1'b0, '0);
        add_row(spq_pkg::REQ_INSERT, 32'sh2, 8'h05, 1, 1'b0, '0);
        add_row(spq_pkg::REQ_INSERT, 32'sh3, 8'h09, 1, 1'b0, '0);
        add_row(spq_pkg::REQ_REMOVE, 32'shFFFF_FFFF, 8'hFF, 3, 1'b0, '0);
        add_row(spq_pkg::REQ_INSERT, 32'sh5555_AAAA, 8'hAA, DEPTH - 1, 1'b0, '0);
        add_row(spq_pkg::REQ_INSERT, 32'shFFFF_FFFF, 8'hFF, 1, 1'b1,
                mk_result(0, 0, spq_pkg::ST_FULL, DEPTH));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            repeat (row.reps)
                send_item(row.req, row.data, row.prio, pick_gap(1'b0), row.typed, row.want);
        end

        ins_pct = 50;
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // swing between filling and draining so full and empty both recur
            if (i % 100 == 0)
            begin
                sel = $urandom_range(0, 2);
                ins_pct = (sel == 0) ? 25 : (sel == 1) ? 50 : 75;
            end
            if ($urandom_range(0, 47) == 0)
                send_quiet = !send_quiet;

            // hold the result side off while offering back to back
            if (i == 400)
            begin
                hold_off_req = 1'b1;
                burst_left = 24;
            end
            // let the block drain completely before carrying on
            if (i == 900)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end

            req = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::REQ_INSERT
                                                    : spq_pkg::REQ_REMOVE;
            sel = $urandom_range(0, 9);
            d = (sel == 0) ? 32'sh7FFF_FFFF :
                (sel == 1) ? 32'sh8000_0000 :
                (sel == 2) ? 32'sh0 : DATA_W'($urandom);
            sel = $urandom_range(0, 9);
            p = (sel < 4)  ? PRIO_PORT_W'($urandom_range(0, 3)) :
                (sel == 4) ? 8'h00 :
                (sel == 5) ? 8'hFF : PRIO_PORT_W'($urandom_range(0, 255));

            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = pick_gap(send_quiet);
            end
            send_item(req, d, p, gap, 1'b0, '0);
        end

        // drain, then allow for the output register
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);

        $display("Ran %0d transactions, %0d results checked, %0d mismatches",
                 items_sent, results_seen, error_count);
        $display("Inserts %0d, removes %0d, dropped when full %0d, empty removes %0d, peak %0d",
                 inserted_n, removed_n, full_n, empty_n, peak_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
